FILE: rtl/pidir_pkg.sv
package pidir_pkg;

	localparam int GainW = 40;
	localparam int AccW  = 64;
	localparam int ErrW  = 33;
	localparam int MagW  = 64;

	localparam logic [GainW-1:0] GainPReset = 40'd5583457485;
	localparam logic [15:0] PLimReset = 16'd20;
	localparam logic [31:0] DLimReset = 32'sd51;

	localparam logic [2:0] RegGainP = 3'd0;
	localparam logic [2:0] RegGainI = 3'd1;
	localparam logic [2:0] RegGainD = 3'd2;
	localparam logic [2:0] RegPLim  = 3'd3;
	localparam logic [2:0] RegDLim  = 3'd4;

	localparam logic [62:0] TermMax = {1'b0, {62{1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC_MUL,
		ST_ACC_ADD,
		ST_DIV,
		ST_D_MUL,
		ST_P_MUL,
		ST_CLEAR,
		ST_I_MUL,
		ST_SUM
	} state_t;

endpackage

FILE: rtl/pid_with_integral_reset_core.sv
// One PID step per transfer. An input transfer carries measurement, target and a
// microsecond timestamp; one output transfer follows with the negated P+I+D drive,
// its saturation flag and the integral-clear flag. Work is done by one bit-serial
// shift-and-add multiplier (used four times: error times elapsed time, P, D and
// I) and one bit-serial divider (for the derivative), sequenced one item at a
// time. When the elapsed time is zero the divide and the D product are skipped.
// The next input is accepted as soon as the result is in the output register,
// even while that result still waits.
module pid_with_integral_reset_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // measurement[31:0], target[63:32], time_us[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive[15:0]
	output logic [1:0]  m_tuser    // drive_saturated[0], integral_cleared[1]
);
	pidir_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [39:0] gain_p_q, gain_i_q, gain_d_q;
	logic [15:0] p_lim_q;
	logic signed [31:0] d_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= pidir_pkg::GainPReset;
			gain_i_q <= '0;
			gain_d_q <= '0;
			p_lim_q  <= pidir_pkg::PLimReset;
			d_lim_q  <= pidir_pkg::DLimReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pidir_pkg::RegGainP: gain_p_q <= cfg_data;
				pidir_pkg::RegGainI: gain_i_q <= cfg_data;
				pidir_pkg::RegGainD: gain_d_q <= cfg_data;
				pidir_pkg::RegPLim:  p_lim_q  <= cfg_data[15:0];
				pidir_pkg::RegDLim:  d_lim_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Loop state.
	logic signed [63:0] acc_q;
	logic signed [32:0] prev_err_q;
	logic [31:0]        prev_time_q;

	// Per-item working registers.
	logic signed [32:0] err_q;
	logic [31:0]        elapsed_q;
	logic signed [63:0] p_q, d_q, i_q;
	logic               cleared_q;

	// Serial units.
	logic         mul_start, mul_done;
	logic         div_start, div_done;
	logic         phase_go_q;
	logic         mul_kick;
	logic [63:0]  mul_a;
	logic [39:0]  mul_b;
	logic [103:0] mul_prod;
	logic [33:0]  div_num;
	logic [33:0]  div_quo;

	// The first product is started from the state decode; the later phases
	// start theirs in the cycle after they are entered.
	assign mul_kick = mul_start || phase_go_q;

	pidir_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_kick), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	pidir_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(elapsed_q), .done(div_done), .quo(div_quo)
	);

	// Error change, needs 34 bits.
	logic signed [33:0] derr;
	logic               derr_neg;
	logic [33:0]        derr_mag;
	assign derr     = {err_q[32], err_q} - {prev_err_q[32], prev_err_q};
	assign derr_neg = derr[33];
	assign derr_mag = derr_neg ? (34'd0 - derr) : derr;
	assign div_num  = derr_mag;

	logic        err_neg;
	logic [32:0] err_mag;
	assign err_neg = err_q[32];
	assign err_mag = err_neg ? (33'd0 - err_q) : err_q;

	logic        acc_neg;
	logic [63:0] acc_mag;
	assign acc_neg = acc_q[63];
	assign acc_mag = acc_neg ? (64'd0 - acc_q) : acc_q;

	// Gain product: shift right 32 of the magnitude and saturate at 2^62-1.
	logic [62:0] term_mag;
	assign term_mag = (mul_prod[103:94] != 10'd0) ? pidir_pkg::TermMax :
		{1'b0, mul_prod[93:32]};

	// Operand selection for the shared multiplier.
	logic signed [33:0] dq_q;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pidir_pkg::ST_ACC_MUL: begin
				mul_a = {31'd0, err_mag};
				mul_b = {8'd0, elapsed_q};
			end
			pidir_pkg::ST_D_MUL: begin
				mul_a = {30'd0, dq_q[33] ? (34'd0 - dq_q) : dq_q};
				mul_b = gain_d_q;
			end
			pidir_pkg::ST_P_MUL: begin
				mul_a = {31'd0, err_mag};
				mul_b = gain_p_q;
			end
			pidir_pkg::ST_I_MUL: begin
				mul_a = acc_mag;
				mul_b = gain_i_q;
			end
			default: ;
		endcase
	end

	// Saturating accumulation of signed error times elapsed. The product is
	// taken straight from the multiplier in the cycle its done pulse is high.
	logic [64:0] acc_sum;
	logic signed [63:0] acc_next;
	always_comb begin
		if (!err_neg) begin
			acc_sum  = {acc_q[63], acc_q} + {1'b0, mul_prod[63:0]};
			acc_next = (acc_sum[64] != acc_sum[63]) ?
				{1'b0, {63{1'b1}}} : acc_sum[63:0];
		end else begin
			acc_sum  = {acc_q[63], acc_q} - {1'b0, mul_prod[63:0]};
			acc_next = (acc_sum[64] != acc_sum[63]) ?
				{1'b1, 63'd0} : acc_sum[63:0];
		end
	end

	// Final sum, truncation toward zero and saturation.
	logic signed [65:0] sum;
	logic signed [65:0] sum_adj;
	logic signed [57:0] quot;
	logic signed [57:0] drv;
	logic [15:0]        drv_sat;
	logic               sat;
	assign sum     = {{2{p_q[63]}}, p_q} + {{2{i_q[63]}}, i_q} + {{2{d_q[63]}}, d_q};
	assign sum_adj = sum + (sum[65] ? 66'sd255 : 66'sd0);
	assign quot    = sum_adj[65:8];
	assign drv     = 58'sd0 - quot;
	always_comb begin
		sat = 1'b1;
		if (drv > 58'sd32767)
			drv_sat = 16'h7fff;
		else if (drv < -58'sd32768)
			drv_sat = 16'h8000;
		else begin
			drv_sat = drv[15:0];
			sat     = 1'b0;
		end
	end

	// Clear rule.
	logic p_big, d_big;
	assign p_big = ((p_q[63] ? (64'd0 - p_q) : p_q) >> 8) > {48'd0, p_lim_q};
	assign d_big = d_q > $signed({{32{d_lim_q[31]}}, d_lim_q});

	logic out_load;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			pidir_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pidir_pkg::ST_ACC_MUL;
				end
			end
			pidir_pkg::ST_ACC_MUL: begin
				mul_start = 1'b1;
				state_d   = pidir_pkg::ST_ACC_ADD;
			end
			pidir_pkg::ST_ACC_ADD: begin
				if (mul_done) begin
					if (elapsed_q == 32'd0) begin
						state_d = pidir_pkg::ST_P_MUL;
					end else begin
						div_start = 1'b1;
						state_d   = pidir_pkg::ST_DIV;
					end
				end
			end
			pidir_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = pidir_pkg::ST_D_MUL;
				end
			end
			pidir_pkg::ST_D_MUL: begin
				if (mul_done) begin
					state_d = pidir_pkg::ST_P_MUL;
				end
			end
			pidir_pkg::ST_P_MUL: begin
				if (mul_done) begin
					state_d = pidir_pkg::ST_CLEAR;
				end
			end
			pidir_pkg::ST_CLEAR: begin
				state_d = pidir_pkg::ST_I_MUL;
			end
			pidir_pkg::ST_I_MUL: begin
				if (mul_done) begin
					state_d = pidir_pkg::ST_SUM;
				end
			end
			pidir_pkg::ST_SUM: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = pidir_pkg::ST_IDLE;
				end
			end
			default: state_d = pidir_pkg::ST_IDLE;
		endcase
	end

	// Each later multiply phase starts its product in the cycle after it is entered.
	// The previous error is kept until the divider has finished with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pidir_pkg::ST_IDLE;
			phase_go_q <= 1'b0;
			acc_q       <= '0;
			prev_err_q  <= '0;
			prev_time_q <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_go_q <= (state_d != state_q) && (state_d == pidir_pkg::ST_D_MUL ||
				state_d == pidir_pkg::ST_P_MUL || state_d == pidir_pkg::ST_I_MUL);
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (out_load)
				m_tvalid <= 1'b1;
			if (state_q == pidir_pkg::ST_ACC_ADD && mul_done) begin
				acc_q       <= acc_next;
				prev_time_q <= prev_time_q + elapsed_q;
			end
			if (state_q == pidir_pkg::ST_CLEAR) begin
				prev_err_q <= err_q;
				if (p_big || d_big)
					acc_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pidir_pkg::ST_IDLE && s_tvalid) begin
			err_q     <= {s_tdata[31], s_tdata[31:0]} - {s_tdata[63], s_tdata[63:32]};
			elapsed_q <= s_tdata[95:64] - prev_time_q;
			d_q       <= '0;
		end
		if (state_q == pidir_pkg::ST_DIV && div_done)
			dq_q <= derr_neg ? (34'd0 - div_quo) : div_quo;
		if (state_q == pidir_pkg::ST_D_MUL && mul_done)
			d_q <= dq_q[33] ? (64'd0 - {1'b0, term_mag}) : {1'b0, term_mag};
		if (state_q == pidir_pkg::ST_P_MUL && mul_done)
			p_q <= err_neg ? (64'd0 - {1'b0, term_mag}) : {1'b0, term_mag};
		if (state_q == pidir_pkg::ST_CLEAR)
			cleared_q <= p_big || d_big;
		if (state_q == pidir_pkg::ST_I_MUL && mul_done)
			i_q <= acc_neg ? (64'd0 - {1'b0, term_mag}) : {1'b0, term_mag};
		if (out_load) begin
			m_tdata <= drv_sat;
			m_tuser <= {cleared_q, sat};
		end
	end
endmodule

FILE: rtl/pidir_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle. Unsigned 64 x 40.
module pidir_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [39:0] b,
	output logic        done,
	output logic [103:0] prod
);
	logic [103:0] acc_q;
	logic [103:0] mcand_q;
	logic [39:0]  mplier_q;
	logic [5:0]   cnt_q;
	logic         busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd39) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {40'd0, a};
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[102:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[39:1]};
		end
	end

	assign prod = acc_q;
endmodule

FILE: rtl/pidir_div.sv
// Restoring divider, one quotient bit per cycle. Unsigned 34 / 32.
module pidir_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [33:0] quo
);
	logic [33:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[33]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd33) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[33]};
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

FILE: sim/pid_with_integral_reset_core_tb.sv
module pid_with_integral_reset_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Items are processed one at a time, with heavy idling on both sides. The limit is
	// several times the slowest correct run.
	localparam longint CycleLimit = 3_000_000;
	localparam int PhaseItems = 225;
	localparam int NumPhases = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [39:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // measurement[31:0], target[63:32], time_us[95:64]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // drive[15:0]
	logic [1:0]  m_tuser;   // drive_saturated[0], integral_cleared[1]

	pid_with_integral_reset_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// One output transfer of the block.
	typedef struct packed {
		logic signed [15:0] drive;
		logic               saturated;
		logic               cleared;
	} drive_result_t;

	// A directed row. When known is set, the expected result is the one typed
	// in the row; otherwise the controller model supplies it.
	typedef struct {
		logic signed [31:0] meas;
		logic signed [31:0] targ;
		logic [31:0]        stamp;
		bit                 known;
		logic signed [15:0] drive;
		bit                 saturated;
		bit                 cleared;
	} sample_row_t;

	// Local copy of the controller registers and state.
	logic [39:0]        kp, ki, kd;
	logic [15:0]        p_limit;
	logic signed [31:0] d_limit;
	longint             integ;
	longint             last_err;
	logic [31:0]        last_stamp;

	drive_result_t pending_drives[$];

	int  send_idle_pct;
	int  recv_stall_pct;
	int  mismatches;
	int  items_sent;
	int  drives_checked;
	int  clears_seen;
	int  sats_seen;
	longint cycles;
	logic [31:0] gen_stamp;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// The run is cut short if the block stops making progress.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d drives outstanding",
				cycles, pending_drives.size());
			$display("pid_with_integral_reset_core_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Signed value times an unsigned Q8.32 gain. The exact product magnitude is
	// shifted right by 32, which truncates toward zero, and clipped to 2^62-1.
	function automatic longint apply_gain(longint v, logic [39:0] g);
		logic [127:0] prod;
		logic [63:0]  m;
		prod = ({64'd0, magnitude(v)} * {88'd0, g}) >> 32;
		m = (prod[127:62] != '0) ? {1'b0, pidir_pkg::TermMax} : prod[63:0];
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// One controller step: updates the local state and returns the drive.
	function automatic drive_result_t pid_step(logic signed [31:0] meas,
			logic signed [31:0] targ, logic [31:0] stamp);
		logic [31:0]        dt;
		longint             err, p_term, i_term, d_term, total, q, drv;
		logic [63:0]        area;
		logic signed [65:0] wide;
		drive_result_t      r;
		dt = stamp - last_stamp;
		err = longint'(meas) - longint'(targ);
		area = magnitude(err) * {32'd0, dt};

		// Accumulate error times elapsed time, saturating at the 64-bit limits.
		wide = err < 0 ? 66'(integ) - $signed({2'b00, area})
			: 66'(integ) + $signed({2'b00, area});
		if (wide > 66'sh0_7FFF_FFFF_FFFF_FFFF)
			integ = 64'h7FFF_FFFF_FFFF_FFFF;
		else if (wide < -66'sh0_8000_0000_0000_0000)
			integ = 64'h8000_0000_0000_0000;
		else
			integ = wide[63:0];

		// A repeated timestamp yields no derivative at all.
		d_term = (dt != 0) ? apply_gain((err - last_err) / longint'({32'd0, dt}), kd) : 0;
		last_stamp = stamp;
		last_err = err;

		p_term = apply_gain(err, kp);
		r.cleared = ((magnitude(p_term) >> 8) > {48'd0, p_limit}) ||
			(d_term > longint'(d_limit));
		if (r.cleared)
			integ = 0;
		i_term = apply_gain(integ, ki);

		// P and D stay far below 2^62, so this sum cannot overflow.
		total = p_term + i_term + d_term;
		q = total / 256;
		drv = -q;
		r.saturated = 1'b0;
		if (drv > 32767) begin
			drv = 32767;
			r.saturated = 1'b1;
		end else if (drv < -32768) begin
			drv = -32768;
			r.saturated = 1'b1;
		end
		r.drive = drv[15:0];
		return r;
	endfunction

	// Called at a falling edge, returns at a falling edge once the write is in.
	task automatic write_reg(logic [2:0] idx, logic [39:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			pidir_pkg::RegGainP: kp = value;
			pidir_pkg::RegGainI: ki = value;
			pidir_pkg::RegGainD: kd = value;
			pidir_pkg::RegPLim:  p_limit = value[15:0];
			pidir_pkg::RegDLim:  d_limit = value[31:0];
			default: ;
		endcase
	endtask

	// Offers one sample and waits for its transfer. Valid stays high into the
	// next sample unless the sender decides to idle.
	task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] targ,
			logic [31:0] stamp, bit known, drive_result_t typed);
		drive_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {stamp, targ, meas};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = pid_step(meas, targ, stamp);
		pending_drives.push_back(known ? typed : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected drive has come back; the block is then idle.
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_drives.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [39:0] pick_gain();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return {8'd0, $urandom()};
			default: return {8'($urandom_range(255)), $urandom()};
		endcase
	endfunction

	// Random sample. Most samples sit close to the target with small steps in
	// time so that the integral builds up; the rest are wide, extreme or small near zero.
	task automatic send_random();
		logic signed [31:0] targ, meas;
		int sel;
		sel = $urandom_range(99);
		targ = $urandom();
		if (sel < 55) begin
			targ = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			meas = targ + $signed($urandom_range(0, 16000)) - 8000;
		end else if (sel < 80) begin
			meas = $urandom();
		end else if (sel < 90) begin
			case ($urandom_range(3))
				0: meas = 32'sh7FFF_FFFF;
				1: meas = 32'sh8000_0000;
				2: meas = 0;
				default: meas = -1;
			endcase
			if ($urandom_range(1))
				targ = -meas - 1;
		end else begin
			meas = $signed($urandom_range(0, 4095)) - 2048;
			targ = $signed($urandom_range(0, 4095)) - 2048;
		end

		sel = $urandom_range(99);
		if (sel < 70)
			gen_stamp = gen_stamp + $urandom_range(1, 2000);
		else if (sel < 80)
			gen_stamp = gen_stamp;
		else if (sel < 90)
			gen_stamp = gen_stamp + $urandom();
		else
			gen_stamp = $urandom();
		send_sample(meas, targ, gen_stamp, 1'b0, '0);
	endtask

	// Output side: ready is redrawn every falling edge and transfers are
	// checked at the rising edge.
	always @(negedge clk) begin
		if (arst_n)
			m_tready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		drive_result_t want;
		drive_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.drive = m_tdata;
			got.saturated = m_tuser[0];
			got.cleared = m_tuser[1];
			if (pending_drives.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: drive %0d with no sample outstanding", $realtime,
						got.drive);
			end else begin
				want = pending_drives.pop_front();
				drives_checked++;
				clears_seen += got.cleared;
				sats_seen += got.saturated;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: drive exp %0d sat %0b clr %0b, got %0d sat %0b clr %0b",
							$realtime, want.drive, want.saturated, want.cleared,
							got.drive, got.saturated, got.cleared);
				end
			end
		end
	end

	sample_row_t directed_rows[] = '{
		// Zero error at timestamp zero after reset: nothing moves.
		'{0, 0, 0, 1, 0, 0, 0},
		'{256, 256, 100, 1, 0, 0, 0},
		// Largest error either way: P far above its limit, drive clipped.
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 200, 1, -32768, 1, 1},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 300, 1, 32767, 1, 1},
		// Same timestamp again: no elapsed time.
		'{0, 0, 300, 0, 0, 0, 0},
		'{5 * 256, 0, 400, 0, 0, 0, 0},
		'{20 * 256, 0, 450, 0, 0, 0, 0},
		'{21 * 256, 0, 470, 0, 0, 0, 0},
		'{-30 * 256, 0, 500, 0, 0, 0, 0},
		'{1000, -1000, 32'hFFFF_FF00, 0, 0, 0, 0},
		// Timestamp wraps through zero.
		'{-1000, 0, 32'h0000_0040, 0, 0, 0, 0},
		'{0, 0, 32'h0000_0040, 0, 0, 0, 0},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1000, 0, 0, 0, 0},
		'{32'sh8000_0000, 32'sh8000_0000, 2000, 0, 0, 0, 0},
		'{32'sh7FFF_FFFF, 0, 2001, 0, 0, 0, 0},
		'{0, 32'sh8000_0000, 2002, 0, 0, 0, 0},
		'{-1, 0, 2003, 0, 0, 0, 0},
		'{1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0}
	};

	initial begin
		drive_result_t typed;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		items_sent = 0;
		drives_checked = 0;
		clears_seen = 0;
		sats_seen = 0;
		cycles = 0;
		kp = pidir_pkg::GainPReset;
		ki = '0;
		kd = '0;
		p_limit = pidir_pkg::PLimReset;
		d_limit = pidir_pkg::DLimReset;
		integ = 0;
		last_err = 0;
		last_stamp = '0;
		gen_stamp = 32'd3000;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed samples with the reset register values.
		foreach (directed_rows[n]) begin
			typed.drive = directed_rows[n].drive;
			typed.saturated = directed_rows[n].saturated;
			typed.cleared = directed_rows[n].cleared;
			send_sample(directed_rows[n].meas, directed_rows[n].targ,
				directed_rows[n].stamp, directed_rows[n].known, typed);
		end

		for (int ph = 0; ph < NumPhases; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase

			// Phase 0 keeps the reset values. The others move every register:
			// all at the top, all at the bottom, a setting that lets the
			// integral run into saturation, then random settings.
			if (ph != 0) begin
				drain();
				case (ph)
					1: begin
						write_reg(pidir_pkg::RegGainP, '1);
						write_reg(pidir_pkg::RegGainI, '1);
						write_reg(pidir_pkg::RegGainD, '1);
						write_reg(pidir_pkg::RegPLim, 40'h00_0000_FFFF);
						write_reg(pidir_pkg::RegDLim, 40'h00_7FFF_FFFF);
					end
					2: begin
						write_reg(pidir_pkg::RegGainP, '0);
						write_reg(pidir_pkg::RegGainI, '0);
						write_reg(pidir_pkg::RegGainD, '0);
						write_reg(pidir_pkg::RegPLim, '0);
						write_reg(pidir_pkg::RegDLim, 40'h00_8000_0000);
					end
					3: begin
						write_reg(pidir_pkg::RegGainP, '0);
						write_reg(pidir_pkg::RegGainI, {8'd0, $urandom_range(1, 255)});
						write_reg(pidir_pkg::RegGainD, '0);
						write_reg(pidir_pkg::RegPLim, 40'h00_0000_FFFF);
						write_reg(pidir_pkg::RegDLim, 40'h00_7FFF_FFFF);
					end
					default: begin
						write_reg(pidir_pkg::RegGainP, pick_gain());
						write_reg(pidir_pkg::RegGainI, pick_gain());
						write_reg(pidir_pkg::RegGainD, pick_gain());
						write_reg(pidir_pkg::RegPLim,
							{8'($urandom_range(255)), $urandom()});
						write_reg(pidir_pkg::RegDLim,
							{8'($urandom_range(255)), $urandom()});
					end
				endcase
				// Indexes past the last register must leave everything alone.
				write_reg(3'($urandom_range(5, 7)), {8'($urandom_range(255)), $urandom()});
			end

			for (int k = 0; k < PhaseItems - (ph == 0 ? directed_rows.size() : 0); k++)
				send_random();
		end

		drain();
		repeat (300) @(negedge clk);

		$display("%0d samples sent, %0d drives checked (%0d integral clears, %0d clipped)",
			items_sent, drives_checked, clears_seen, sats_seen);
		$display("%0d register phases over four idle and stall mixes, %0d mismatches",
			NumPhases, mismatches);
		if (mismatches == 0 && pending_drives.size() == 0)
			$display("pid_with_integral_reset_core_tb: PASS");
		else
			$display("pid_with_integral_reset_core_tb: FAIL");
		$finish;
	end

endmodule
